// ----- src/statistics_counter_bank_top_macros.svh -----
// ----------------------------------------------------------------------------
// statistics counter bank assertion macros
// shared property wrappers for the counter bank checks
// ----------------------------------------------------------------------------
`ifndef STATISTICS_COUNTER_BANK_TOP_MACROS_SVH
`define STATISTICS_COUNTER_BANK_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define SCB_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("statistics counter bank check failed");

// next-cycle implication, disabled while reset is high
`define SCB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("statistics counter bank check failed");

`endif

// ----- src/scb_pkg.sv -----
// ----------------------------------------------------------------------------
// scb_pkg
// beat types and operation codes of the statistics counter bank
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scb_pkg;

   localparam int unsigned VALUE_W = 64;
   localparam int unsigned COUNT_W = 32;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned FUNC_W  = 3;
   localparam int unsigned INUSE_W = 7;

   localparam logic [FUNC_W-1:0] FUNC_ADD       = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_SET       = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_MAX       = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_AVERAGE   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_RESET_ONE = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_RESET_ALL = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_NOP       = 3'd7;

   localparam logic [INUSE_W-1:0] INUSE_RESET = 7'd62;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic [INDEX_W-1:0]        stat_index;
      logic signed [VALUE_W-1:0] operand;
   } scb_req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      ignored;
   } scb_rsp_type;

endpackage

// ----- src/scb_div.sv -----
// ----------------------------------------------------------------------------
// scb_div
// radix-2 restoring divider, signed 64-bit dividend by unsigned 32-bit divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scb_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic signed [scb_pkg::VALUE_W-1:0] dividend,
   input  logic [scb_pkg::COUNT_W-1:0]      divisor,
   output logic                             done,
   output logic signed [scb_pkg::VALUE_W-1:0] quotient
);
   import scb_pkg::*;

   localparam int unsigned STEP_W = $clog2(VALUE_W);

   logic                busy_ff;
   logic                fin_ff;
   logic                done_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                neg_ff;
   logic [COUNT_W-1:0]  rem_ff;
   logic [COUNT_W-1:0]  rem_in;
   logic [COUNT_W-1:0]  dsr_ff;
   logic [VALUE_W-1:0]  dvd_ff;
   logic [VALUE_W-1:0]  dvd_in;
   logic [VALUE_W-1:0]  mag;
   logic [VALUE_W-1:0]  quo_ff;
   logic [COUNT_W:0]    shifted;
   logic [COUNT_W:0]    trial;
   logic                fits;

   // magnitude of the dividend, the most negative value maps to 2^63
   assign mag = dividend[VALUE_W-1] ? (~dividend + 1'b1) : dividend;

   // one quotient bit per cycle, quotient bits shift in behind the dividend
   assign shifted = {rem_ff, dvd_ff[VALUE_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = shifted >= {1'b0, dsr_ff};
   assign rem_in  = fits ? trial[COUNT_W-1:0] : shifted[COUNT_W-1:0];
   assign dvd_in  = {dvd_ff[VALUE_W-2:0], fits};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= fin_ff && !start && !busy_ff;
         if (start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
            rem_ff  <= '0;
            dvd_ff  <= mag;
            dsr_ff  <= divisor;
            neg_ff  <= dividend[VALUE_W-1];
         end else if (busy_ff) begin
            rem_ff  <= rem_in;
            dvd_ff  <= dvd_in;
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end
         end else if (fin_ff) begin
            fin_ff  <= 1'b0;
            quo_ff  <= neg_ff ? (~dvd_ff + 1'b1) : dvd_ff;
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- src/statistics_counter_bank_top.sv -----
// ----------------------------------------------------------------------------
// statistics_counter_bank_top
// bank of signed 64-bit statistics with per-entry running-average counts
// ----------------------------------------------------------------------------
// channel | direction | handshake              | beat
// req     | in        | req_valid / req_ready  | func, stat_index, operand
// rsp     | out       | rsp_valid / rsp_ready  | value, ignored
// csr     | in        | csr_valid / csr_ready  | stats_in_use (7 bits)
//
// add, set, max, reset one and read pass through S_EXEC to S_RESP
// average waits in S_DIV for the one-bit-a-step divider; ignored and nop go straight to S_RESP
// reset all walks S_SWEEP, one value row cleared per cycle, then goes to S_RESP
// after reset a clearing pass loads value 0 and count 1
// into every row; req_ready stays low during it, csr writes are taken
// a stalled rsp holds its beat; the next req is taken while it waits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "statistics_counter_bank_top_macros.svh"

module statistics_counter_bank_top #(
   parameter int unsigned NUM_ENTRIES = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  scb_pkg::scb_req_type         req_beat,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output scb_pkg::scb_rsp_type         rsp_beat,
   // configuration channel
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [scb_pkg::INUSE_W-1:0]  csr_data
);
   import scb_pkg::*;

   localparam int unsigned IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_SWEEP,
      S_RESP
   } state_type;

   // storage: value rows and average-count rows, one write and one read port
   logic [VALUE_W-1:0] val_mem [NUM_ENTRIES];
   logic [COUNT_W-1:0] cnt_mem [NUM_ENTRIES];

   state_type          state_ff;
   logic [IDX_W-1:0]   sweep_ff;
   logic [IDX_W-1:0]   addr_ff;
   scb_req_type        req_ff;
   logic [VALUE_W-1:0] rd_val_ff;
   logic [COUNT_W-1:0] rd_cnt_ff;
   logic [VALUE_W-1:0] res_value_ff;
   logic               res_ign_ff;
   logic               rsp_valid_ff;
   scb_rsp_type        rsp_beat_ff;
   logic [INUSE_W-1:0] in_use_ff;

   logic               req_fire;
   logic [IDX_W+INDEX_W-1:0] req_index_ext;
   logic [IDX_W-1:0]   req_addr;
   logic               req_ign;
   logic               rsp_load;

   logic               val_we;
   logic [IDX_W-1:0]   val_waddr;
   logic [VALUE_W-1:0] val_wdata;
   logic               cnt_we;
   logic [IDX_W-1:0]   cnt_waddr;
   logic [COUNT_W-1:0] cnt_wdata;

   logic [VALUE_W-1:0] exec_value;
   logic [COUNT_W-1:0] divisor;
   logic [COUNT_W-1:0] cnt_next;
   logic [VALUE_W-1:0] avg_value;
   logic signed [VALUE_W-1:0] avg_diff;
   logic               div_start;
   logic               div_done;
   logic signed [VALUE_W-1:0] div_quotient;
   logic               sweep_last;

   // ------------------------------------------------------------------
   // handshakes
   // ------------------------------------------------------------------
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   // the output register takes a new beat once it is free or being drained
   assign rsp_load  = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= INUSE_RESET;
      end else if (csr_valid && csr_ready) begin
         in_use_ff <= csr_data;
      end
   end

   // index into the bank, widened so any bank depth can take it
   assign req_index_ext = {{IDX_W{1'b0}}, req_beat.stat_index};
   assign req_addr      = req_index_ext[IDX_W-1:0];

   // an entry past the registered count or past the bank is left alone
   assign req_ign = (req_beat.func != FUNC_RESET_ALL) && (req_beat.func != FUNC_NOP) &&
                    (({1'b0, req_beat.stat_index} >= in_use_ff) ||
                     (32'(req_beat.stat_index) >= NUM_ENTRIES));

   assign sweep_last = (sweep_ff == IDX_W'(NUM_ENTRIES - 1));

   // ------------------------------------------------------------------
   // read-modify-write datapath
   // ------------------------------------------------------------------
   always_comb begin
      unique case (req_ff.func)
         FUNC_ADD:       exec_value = rd_val_ff + req_ff.operand;
         FUNC_SET:       exec_value = req_ff.operand;
         FUNC_MAX:       exec_value = ($signed(rd_val_ff) < req_ff.operand) ?
                                      req_ff.operand : rd_val_ff;
         FUNC_RESET_ONE: exec_value = '0;
         default:        exec_value = rd_val_ff;
      endcase
   end

   // a zero count is read as one, and a count that wraps restarts at one
   assign divisor   = (rd_cnt_ff == '0) ? COUNT_W'(1) : rd_cnt_ff;
   assign cnt_next  = ((divisor + 1'b1) == '0) ? COUNT_W'(1) : (divisor + 1'b1);
   assign avg_diff  = req_ff.operand - $signed(rd_val_ff);
   assign avg_value = div_quotient + rd_val_ff;

   assign div_start = (state_ff == S_EXEC) && (req_ff.func == FUNC_AVERAGE);

   scb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (avg_diff),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // write port steering
   always_comb begin
      val_we    = 1'b0;
      val_waddr = addr_ff;
      val_wdata = exec_value;
      cnt_we    = 1'b0;
      cnt_waddr = addr_ff;
      cnt_wdata = cnt_next;
      unique case (state_ff)
         S_CLEAR: begin
            val_we    = 1'b1;
            val_waddr = sweep_ff;
            val_wdata = '0;
            cnt_we    = 1'b1;
            cnt_waddr = sweep_ff;
            cnt_wdata = COUNT_W'(1);
         end
         S_SWEEP: begin
            val_we    = 1'b1;
            val_waddr = sweep_ff;
            val_wdata = '0;
         end
         S_EXEC: begin
            val_we = (req_ff.func != FUNC_AVERAGE);
         end
         S_DIV: begin
            val_we    = div_done;
            val_wdata = avg_value;
            cnt_we    = div_done;
         end
         default: begin
            val_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_waddr] <= val_wdata;
      end
      if (req_fire) begin
         rd_val_ff <= val_mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (req_fire) begin
         rd_cnt_ff <= cnt_mem[req_addr];
      end
   end

   // ------------------------------------------------------------------
   // sequencer and response register
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_CLEAR: begin
               if (sweep_last) begin
                  sweep_ff <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_fire) begin
                  req_ff       <= req_beat;
                  addr_ff      <= req_addr;
                  res_value_ff <= '0;
                  res_ign_ff   <= req_ign;
                  if (req_beat.func == FUNC_RESET_ALL) begin
                     sweep_ff <= '0;
                     state_ff <= S_SWEEP;
                  end else if (req_ign || (req_beat.func == FUNC_NOP)) begin
                     state_ff <= S_RESP;
                  end else begin
                     state_ff <= S_EXEC;
                  end
               end
            end
            S_EXEC: begin
               res_value_ff <= exec_value;
               state_ff     <= (req_ff.func == FUNC_AVERAGE) ? S_DIV : S_RESP;
            end
            S_DIV: begin
               if (div_done) begin
                  res_value_ff <= avg_value;
                  state_ff     <= S_RESP;
               end
            end
            S_SWEEP: begin
               if (sweep_last) begin
                  sweep_ff <= '0;
                  state_ff <= S_RESP;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            S_RESP: begin
               // hand over once the output register is free or being drained
               if (rsp_load) begin
                  rsp_beat_ff.value   <= res_value_ff;
                  rsp_beat_ff.ignored <= res_ign_ff;
                  state_ff            <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // checks
   // ------------------------------------------------------------------
   `SCB_ASSERT_NEXT(a_one_in_flight, clock, reset, req_fire, !req_ready)
   `SCB_ASSERT_NOW(a_div_done_in_div, clock, reset, div_done, state_ff == S_DIV)
   `SCB_ASSERT_NOW(a_cnt_write_owner, clock, reset, cnt_we,
                   (state_ff == S_CLEAR) || (state_ff == S_DIV))
   `SCB_ASSERT_NOW(a_ignored_is_zero, clock, reset, rsp_valid_ff && rsp_beat_ff.ignored,
                   rsp_beat_ff.value == '0)

endmodule
